/* design/ctcr_pkg.sv */
// Shared constants and types for the columnar transposition cipher with keyed
// byte rotation. Used by the top level, ctcr_rot and the testbench; depends on nothing.
package ctcr_pkg;

  localparam int MAX_BYTES = 64;
  localparam int KEY_MAX   = 16;

  localparam int BYTE_W    = 8;
  localparam int ROT_W     = 3;
  localparam int KEY_LEN_W = 5;
  localparam int KEY_ROT_W = 48;
  localparam int CFG_IDX_W = 1;

  localparam int ADDR_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int CNT_W  = $clog2(MAX_BYTES + 1);
  localparam int KIDX_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ROTATIONS = CFG_IDX_W'(1);

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [ROT_W-1:0]  rot_t;

endpackage

/* design/columnar_transpose_rotate_cipher.sv */
// Top level of the columnar transposition cipher with keyed byte rotation.
// Depends on ctcr_pkg, ctcr_ram and ctcr_rot.
//
// Message bytes are taken one per cycle into a 64-entry store until the beat
// marked last; bytes beyond the store's capacity are dropped and every result
// of that message carries truncated. The input then stays not ready while the
// message is emitted in column order, each byte rotated right by the key entry
// for its output position. Each byte is emitted through the states S_READ,
// which reads the store's port, and S_FILL, which passes the byte through the
// shared rotator into the output register and waits while the output side
// stalls. Configuration writes are always accepted and must be made only
// while no message is in flight.
module columnar_transpose_rotate_cipher (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ctcr_pkg::BYTE_W-1:0]        in_data_byte,
  input  logic                               in_last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ctcr_pkg::BYTE_W-1:0]        out_byte,
  output logic                               out_last,
  output logic                               out_truncated,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ctcr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ctcr_pkg::KEY_ROT_W-1:0]     cfg_data
);

  typedef enum logic [1:0] {S_LOAD, S_READ, S_FILL} state_t;

  localparam int CNT_W  = ctcr_pkg::CNT_W;
  localparam int KIDX_W = ctcr_pkg::KIDX_W;
  localparam int LEN_W  = ctcr_pkg::KEY_LEN_W;

  state_t                         state_r, state_nxt;
  logic [CNT_W-1:0]               count_r, count_nxt;
  logic                           overflow_r, overflow_nxt;
  logic [CNT_W-1:0]               pos_r, pos_nxt;
  logic [CNT_W-1:0]               col_r, col_nxt;
  logic [KIDX_W-1:0]              ki_r, ki_nxt;
  logic [CNT_W-1:0]               j_r, j_nxt;
  logic [LEN_W-1:0]               key_length_r;
  logic [ctcr_pkg::KEY_ROT_W-1:0] key_rotations_r;
  logic                           out_valid_r, out_valid_nxt;
  ctcr_pkg::byte_t                out_byte_r, out_byte_nxt;
  logic                           out_last_r, out_last_nxt;
  logic                           trunc_r, trunc_nxt;

  logic [LEN_W-1:0]       eff_len;
  logic                   in_acc;
  logic                   store_we;
  logic                   ram_re;
  ctcr_pkg::byte_t        ram_rdata;
  ctcr_pkg::byte_t        rot_byte;
  ctcr_pkg::rot_t         rot_amt;
  logic                   out_free;
  logic                   final_beat;
  logic [CNT_W:0]         pos_sum;
  logic [KIDX_W:0]        ki_inc;

  always_comb begin
    if (key_length_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (key_length_r > LEN_W'(ctcr_pkg::KEY_MAX)) begin
      eff_len = LEN_W'(ctcr_pkg::KEY_MAX);
    end else begin
      eff_len = key_length_r;
    end
  end

  assign in_ready  = (state_r == S_LOAD);
  assign in_acc    = in_valid && in_ready;
  assign store_we  = in_acc && (count_r < CNT_W'(ctcr_pkg::MAX_BYTES));
  assign ram_re    = (state_r == S_READ);
  assign cfg_ready = 1'b1;

  assign rot_amt    = key_rotations_r[ctcr_pkg::ROT_W*ki_r +: ctcr_pkg::ROT_W];
  assign out_free   = !out_valid_r || out_ready;
  assign final_beat = (CNT_W'(j_r + CNT_W'(1)) == count_r);
  assign pos_sum    = {1'b0, pos_r} + (CNT_W+1)'(eff_len);
  assign ki_inc     = {1'b0, ki_r} + (KIDX_W+1)'(1);

  ctcr_ram #(
    .WIDTH(ctcr_pkg::BYTE_W),
    .DEPTH(ctcr_pkg::MAX_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (store_we),
    .waddr(count_r[ctcr_pkg::ADDR_W-1:0]),
    .wdata(in_data_byte),
    .re   (ram_re),
    .raddr(pos_r[ctcr_pkg::ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  ctcr_rot u_rot (
    .data_in (ram_rdata),
    .amount  (rot_amt),
    .data_out(rot_byte)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    overflow_nxt  = overflow_r;
    pos_nxt       = pos_r;
    col_nxt       = col_r;
    ki_nxt        = ki_r;
    j_nxt         = j_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    trunc_nxt     = trunc_r;

    unique case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (store_we) begin
            count_nxt = count_r + CNT_W'(1);
          end else begin
            overflow_nxt = 1'b1;
          end
          if (in_last) begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        state_nxt = S_FILL;
      end
      S_FILL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = rot_byte;
          out_last_nxt  = final_beat;
          trunc_nxt     = overflow_r;
          if (final_beat) begin
            state_nxt    = S_LOAD;
            count_nxt    = '0;
            overflow_nxt = 1'b0;
            pos_nxt      = '0;
            col_nxt      = '0;
            ki_nxt       = '0;
            j_nxt        = '0;
          end else begin
            state_nxt = S_READ;
            j_nxt     = j_r + CNT_W'(1);
            if (pos_sum < {1'b0, count_r}) begin
              pos_nxt = pos_sum[CNT_W-1:0];
            end else begin
              col_nxt = col_r + CNT_W'(1);
              pos_nxt = col_r + CNT_W'(1);
            end
            if (LEN_W'(ki_inc) >= eff_len) begin
              ki_nxt = '0;
            end else begin
              ki_nxt = ki_inc[KIDX_W-1:0];
            end
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_LOAD;
      count_r         <= '0;
      overflow_r      <= 1'b0;
      pos_r           <= '0;
      col_r           <= '0;
      ki_r            <= '0;
      j_r             <= '0;
      out_valid_r     <= 1'b0;
      key_length_r    <= LEN_W'(1);
      key_rotations_r <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      overflow_r  <= overflow_nxt;
      pos_r       <= pos_nxt;
      col_r       <= col_nxt;
      ki_r        <= ki_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ctcr_pkg::REG_KEY_LENGTH) begin
          key_length_r <= cfg_data[LEN_W-1:0];
        end else if (cfg_index == ctcr_pkg::REG_KEY_ROTATIONS) begin
          key_rotations_r <= cfg_data;
        end
      end
    end
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    trunc_r    <= trunc_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_last      = out_last_r;
  assign out_truncated = trunc_r;

endmodule

/* design/ctcr_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module ctcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

/* design/ctcr_rot.sv */
// Byte rotator shared by every emitted byte: rotates right by a 3-bit amount.
// Depends on ctcr_pkg.
module ctcr_rot (
  input  ctcr_pkg::byte_t data_in,
  input  ctcr_pkg::rot_t  amount,
  output ctcr_pkg::byte_t data_out
);

  logic [2*ctcr_pkg::BYTE_W-1:0] dbl;

  assign dbl      = {data_in, data_in} >> amount;
  assign data_out = dbl[ctcr_pkg::BYTE_W-1:0];

endmodule

/* tb/sv/columnar_transpose_rotate_cipher_tb.sv */
// Self-checking testbench for columnar_transpose_rotate_cipher: directed and random messages,
// predicted transposed and rotated beats compared field by field. Depends on ctcr_pkg and the RTL.
module columnar_transpose_rotate_cipher_tb;
  import ctcr_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 8;

  typedef struct packed {
    byte_t data;
    logic  last;
    logic  trunc;
  } cipher_beat_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [BYTE_W-1:0]    in_data_byte;
  logic                 in_last;
  logic                 out_valid;
  logic                 out_ready;
  logic [BYTE_W-1:0]    out_byte;
  logic                 out_last;
  logic                 out_truncated;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [KEY_ROT_W-1:0] cfg_data;

  byte_t                model_store [MAX_BYTES];
  int                   model_count;
  bit                   model_dropped;
  logic [KEY_LEN_W-1:0] model_key_len;
  logic [KEY_ROT_W-1:0] model_key_rot;

  cipher_beat_t expected_beats [$];

  bit in_driving;
  bit calm;
  int ready_hold;
  int error_count;
  int bytes_sent;
  int messages_sent;
  int truncated_messages;
  int beats_checked;
  int config_writes;
  int cycle_count;

  columnar_transpose_rotate_cipher dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_last      (out_last),
    .out_truncated (out_truncated),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (calm) return 0;
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic byte_t random_byte();
    if ($urandom_range(0, 15) == 0) return 8'h00;
    return byte_t'($urandom_range(1, 255));
  endfunction

  // Stores a byte (dropped if full); on the final byte, queues the whole enciphered message.
  task automatic absorb_byte(input byte_t data, input bit is_last);
    int           cols;
    int           pos;
    int           key_idx;
    int           beat_idx;
    logic [15:0]  doubled;
    logic [2:0]   amount;
    cipher_beat_t beat;
    if (model_count < MAX_BYTES) begin
      model_store[model_count] = data;
      model_count++;
    end else begin
      model_dropped = 1'b1;
    end
    if (is_last) begin
      cols = int'(model_key_len);
      if (cols == 0) cols = 1;
      if (cols > KEY_MAX) cols = KEY_MAX;
      key_idx = 0;
      beat_idx = 0;
      for (int col = 0; col < cols; col++) begin
        for (pos = col; pos < model_count; pos += cols) begin
          amount = model_key_rot[3*key_idx +: 3];
          doubled = {model_store[pos], model_store[pos]} >> amount;
          beat.data = doubled[7:0];
          beat.last = (beat_idx + 1 == model_count);
          beat.trunc = model_dropped;
          expected_beats.push_back(beat);
          beat_idx++;
          key_idx = (key_idx + 1 >= cols) ? 0 : key_idx + 1;
        end
      end
      messages_sent++;
      if (model_dropped) truncated_messages++;
      model_count = 0;
      model_dropped = 1'b0;
    end
  endtask

  task automatic send_byte(input byte_t data, input bit is_last);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      if (in_driving) begin
        in_valid <= 1'b0;
        in_driving = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= data;
    in_last <= is_last;
    in_driving = 1'b1;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    absorb_byte(data, is_last);
  endtask

  task automatic park_input();
    if (in_driving) begin
      in_valid <= 1'b0;
      in_driving = 1'b0;
    end
  endtask

  task automatic wait_drained();
    park_input();
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_ROT_W-1:0] data);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    config_writes++;
    if (idx == REG_KEY_LENGTH) model_key_len = data[KEY_LEN_W-1:0];
    else model_key_rot = data;
  endtask

  task automatic set_key(input int len, input logic [KEY_ROT_W-1:0] rot);
    write_reg(REG_KEY_LENGTH, KEY_ROT_W'(len));
    write_reg(REG_KEY_ROTATIONS, rot);
  endtask

  task automatic set_random_key();
    logic [63:0] rot;
    int          len;
    rot = {$urandom(), $urandom()};
    len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
    set_key(len, rot[KEY_ROT_W-1:0]);
  endtask

  task automatic send_random_message(input int len);
    for (int i = 0; i < len; i++) send_byte(random_byte(), i == len - 1);
  endtask

  task automatic test_reset_defaults();
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_key_extremes();
    set_key(16, 48'hFFFF_FFFF_FFFF);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
  endtask

  task automatic test_key_length_zero();
    set_key(0, 48'h0000_0000_0003);
    send_byte(8'h81, 1'b0);
    send_byte(8'h7E, 1'b1);
  endtask

  task automatic test_key_length_saturation();
    set_key(31, 48'h0000_00FA_C688);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    send_byte(8'h78, 1'b1);
    write_reg(REG_KEY_LENGTH, KEY_ROT_W'(17));
    send_byte(8'hC3, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hF0, 1'b1);
  endtask

  task automatic test_rotation_amounts();
    set_key(8, 48'h0000_00FA_C688);
    for (int i = 0; i < 8; i++) send_byte(8'h81, i == 7);
  endtask

  task automatic test_store_overflow();
    set_random_key();
    send_random_message(MAX_BYTES + 2);
  endtask

  task automatic test_back_to_back();
    wait_drained();
    calm = 1'b1;
    for (int m = 0; m < 3; m++) send_random_message($urandom_range(3, 8));
    wait_drained();
    calm = 1'b0;
  endtask

  task automatic test_pause_for_drain();
    send_random_message($urandom_range(3, 6));
    wait_drained();
    send_random_message($urandom_range(3, 6));
  endtask

  task automatic test_random_messages(input int byte_goal);
    int start;
    int len;
    start = bytes_sent;
    while (bytes_sent - start < byte_goal) begin
      if ($urandom_range(0, 2) == 0) set_random_key();
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, MAX_BYTES) : $urandom_range(1, 20);
      send_random_message(len);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      ready_hold <= 0;
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else if (ready_hold == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        out_ready <= 1'b1;
        ready_hold <= $urandom_range(1, 20);
      end else begin
        out_ready <= 1'b0;
        ready_hold <= gap_len();
      end
    end else begin
      ready_hold <= ready_hold - 1;
    end
  end

  always @(posedge clk) begin
    cipher_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected beat: out_byte %h out_last %b out_truncated %b",
               out_byte, out_last, out_truncated);
        error_count++;
      end else begin
        want = expected_beats.pop_front();
        beats_checked++;
        if (out_byte !== want.data) begin
          $error("out_byte: expected %h, actual %h", want.data, out_byte);
          error_count++;
        end
        if (out_last !== want.last) begin
          $error("out_last: expected %b, actual %b", want.last, out_last);
          error_count++;
        end
        if (out_truncated !== want.trunc) begin
          $error("out_truncated: expected %b, actual %b", want.trunc, out_truncated);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data_byte <= '0;
    in_last <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_KEY_LENGTH;
    cfg_data <= '0;
    in_driving = 1'b0;
    calm = 1'b0;
    model_count = 0;
    model_dropped = 1'b0;
    model_key_len = KEY_LEN_W'(1);
    model_key_rot = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_key_extremes();
    test_key_length_zero();
    test_key_length_saturation();
    test_rotation_amounts();
    test_store_overflow();
    test_back_to_back();
    test_pause_for_drain();
    test_random_messages(30);
    set_key(1, '0);
    send_random_message(4);
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Sent %0d bytes in %0d messages (%0d truncated); checked %0d beats.",
             bytes_sent, messages_sent, truncated_messages, beats_checked);
    $display("Made %0d register writes, including zero and oversized key lengths.",
             config_writes);
    if (error_count == 0 && expected_beats.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* columnar_transpose_rotate_cipher.f */
design/ctcr_pkg.sv
design/ctcr_ram.sv
design/ctcr_rot.sv
design/columnar_transpose_rotate_cipher.sv
tb/sv/columnar_transpose_rotate_cipher_tb.sv
